// ----- hdl/heightmap_lambert_shading_core_assert.svh -----
// Assertion macros for the heightmap Lambert shading core.
`ifndef HEIGHTMAP_LAMBERT_SHADING_CORE_ASSERT_SVH
`define HEIGHTMAP_LAMBERT_SHADING_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define HLS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define HLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/hls_pkg.sv -----
// Shared constants, types and helpers for the heightmap Lambert shading core.
`default_nettype none
package hls_pkg;

    // port widths
    localparam int IN_W       = 24;
    localparam int LIGHT_W    = 16;
    localparam int AMB_W      = 16;
    localparam int SCALE_W    = 13;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CH_W       = 8;

    // internal datapath widths
    localparam int DIFF_W  = 26;
    localparam int SLOPE_W = 39;
    localparam int MAGA_W  = 38;
    localparam int K_W     = 4;
    localparam int MAG_W   = 26;
    localparam int SMAG_W  = 27;
    localparam int ONEP_W  = 21;
    localparam int SQ_W    = 52;
    localparam int PX_W    = 43;
    localparam int S2_W    = 54;
    localparam int N_W     = 45;
    localparam int SQRT_PAD = 8;
    localparam int RAD_S_W = S2_W + SQRT_PAD;
    localparam int RS_W    = RAD_S_W / 2;
    localparam int L2_W    = 32;
    localparam int L_PAD   = 20;
    localparam int RAD_L_W = L2_W + L_PAD;
    localparam int RL_W    = RAD_L_W / 2;
    localparam int T_SHIFT = 16;
    localparam int X1_W    = N_W - 1 + T_SHIFT;
    localparam int T_W     = 28;
    localparam int C_SHIFT = 14;
    localparam int Z_SHIFT = 20;
    localparam int X2_W    = T_W + C_SHIFT;
    localparam int C_W     = 17;
    localparam int CM_W    = 34;
    localparam int BR_W    = 17;
    localparam int WW_W    = 21;
    localparam int INV_W   = 22;
    localparam int P1_W    = 46;
    localparam int P2_W    = 48;
    localparam int BS_W    = 49;
    localparam int COMP_W  = 27;
    localparam int PR_W    = 45;
    localparam int PS_W    = 53;
    localparam int CH_SHIFT = 36;

    // fixed-point constants
    localparam int ONE_Q20        = 1 << 20;
    localparam int WATER_EPS_RAW  = 104;
    localparam int DEEP_RAW       = 1049;
    localparam int WATER_MULT     = 1000;
    localparam int C_MAX          = 1 << 16;

    localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = -16'sd8192;
    localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = -16'sd1638;
    localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = -16'sd8192;
    localparam logic [AMB_W-1:0]          AMB_RST     = 16'd3277;
    localparam logic [SCALE_W-1:0]        SCALE_RST   = 13'd257;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_X = 3'd0,
        REG_LIGHT_Y = 3'd1,
        REG_LIGHT_Z = 3'd2,
        REG_AMBIENT = 3'd3,
        REG_SCALE   = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        COL_LAND,
        COL_RAMP,
        COL_DEEP
    } col_class_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] r;
        logic signed [COMP_W-1:0] g;
        logic signed [COMP_W-1:0] b;
    } color_t;

    typedef struct packed {
        logic signed [N_W-1:0] n;
        logic [ONEP_W-1:0]     onep;
        color_t                col;
    } sqrt_sb_t;

    typedef struct packed {
        logic [RS_W-1:0]   rs;
        logic [ONEP_W-1:0] onep;
        logic              npos;
        color_t            col;
    } div1_sb_t;

    typedef struct packed {
        logic   cz;
        color_t col;
    } div2_sb_t;

    // floor(pr*255 / 2^36), saturated to 0..255
    function automatic logic [CH_W-1:0] sat_channel(input logic signed [PR_W-1:0] pr);
        logic signed [PS_W-1:0] ps;
        logic [CH_W-1:0]        res;
        ps = (PS_W'(pr) <<< 8) - PS_W'(pr);
        if (ps <= 0)
        begin
            res = '0;
        end
        else if (ps[PS_W-1:CH_SHIFT+CH_W] != '0)
        begin
            res = '1;
        end
        else
        begin
            res = ps[CH_SHIFT+CH_W-1:CH_SHIFT];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/hls_isqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband.
`default_nettype none
module hls_isqrt #(
    parameter int RAD_W = 62,
    parameter int SB_W  = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [RAD_W-1:0]     rad,
    input  logic [SB_W-1:0]      sb_in,
    output logic                 out_valid,
    output logic [RAD_W/2-1:0]   root,
    output logic [SB_W-1:0]      sb_out
);
    localparam int R    = RAD_W / 2;
    localparam int RM_W = R + 2;

    logic [R-1:0]     v_reg;
    logic [R-1:0]     root_reg [R];
    logic [RM_W-1:0]  rem_reg  [R];
    logic [RAD_W-1:0] rad_reg  [R];
    logic [SB_W-1:0]  sb_reg   [R];

    logic [R-1:0]     root_p    [R];
    logic [RM_W-1:0]  rem_p     [R];
    logic [RAD_W-1:0] rad_p     [R];
    logic [SB_W-1:0]  sb_p      [R];
    logic [RM_W-1:0]  rem_sh    [R];
    logic [RM_W-1:0]  trial     [R];
    logic [R-1:0]     root_next [R];
    logic [RM_W-1:0]  rem_next  [R];

    always_comb
    begin
        for (int i = 0; i < R; i++)
        begin
            if (i == 0)
            begin
                root_p[i] = '0;
                rem_p[i]  = '0;
                rad_p[i]  = rad;
                sb_p[i]   = sb_in;
            end
            else
            begin
                root_p[i] = root_reg[i-1];
                rem_p[i]  = rem_reg[i-1];
                rad_p[i]  = rad_reg[i-1];
                sb_p[i]   = sb_reg[i-1];
            end
            rem_sh[i] = {rem_p[i][R-1:0], rad_p[i][RAD_W-1-2*i -: 2]};
            trial[i]  = {root_p[i], 2'b01};
            if (rem_sh[i] >= trial[i])
            begin
                rem_next[i]  = rem_sh[i] - trial[i];
                root_next[i] = {root_p[i][R-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = rem_sh[i];
                root_next[i] = {root_p[i][R-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[R-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < R; i++)
            begin
                root_reg[i] <= root_next[i];
                rem_reg[i]  <= rem_next[i];
                rad_reg[i]  <= rad_p[i];
                sb_reg[i]   <= sb_p[i];
            end
        end
    end

    assign out_valid = v_reg[R-1];
    assign root      = root_reg[R-1];
    assign sb_out    = sb_reg[R-1];

endmodule
`default_nettype wire

// ----- hdl/hls_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, overflow flag, sideband.
`default_nettype none
module hls_div #(
    parameter int X_W  = 60,
    parameter int D_W  = 31,
    parameter int Q_W  = 28,
    parameter int SB_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [X_W-1:0]   x,
    input  logic [D_W-1:0]   d,
    input  logic [SB_W-1:0]  sb_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   q,
    output logic             ovf,
    output logic [SB_W-1:0]  sb_out
);
    localparam int HI_W = X_W - Q_W;
    localparam int EX_W = HI_W + D_W;

    logic [EX_W-1:0] hi_ext;
    logic            ovf0;

    logic [Q_W-1:0]  v_reg;
    logic [D_W-1:0]  rem_reg [Q_W];
    logic [Q_W-1:0]  q_reg   [Q_W];
    logic [Q_W-1:0]  xl_reg  [Q_W];
    logic [D_W-1:0]  d_reg   [Q_W];
    logic [Q_W-1:0]  ovf_reg;
    logic [SB_W-1:0] sb_reg  [Q_W];

    logic [D_W-1:0]  rem_p    [Q_W];
    logic [Q_W-1:0]  q_p      [Q_W];
    logic [Q_W-1:0]  xl_p     [Q_W];
    logic [D_W-1:0]  d_p      [Q_W];
    logic [Q_W-1:0]  ovf_p;
    logic [SB_W-1:0] sb_p     [Q_W];
    logic [D_W:0]    trial    [Q_W];
    logic [D_W-1:0]  rem_next [Q_W];
    logic [Q_W-1:0]  q_next   [Q_W];

    // quotient does not fit Q_W bits when the top part already reaches d
    assign hi_ext = {{D_W{1'b0}}, x[X_W-1:Q_W]};
    assign ovf0   = hi_ext >= {{HI_W{1'b0}}, d};

    always_comb
    begin
        for (int i = 0; i < Q_W; i++)
        begin
            if (i == 0)
            begin
                rem_p[i]  = hi_ext[D_W-1:0];
                q_p[i]    = '0;
                xl_p[i]   = x[Q_W-1:0];
                d_p[i]    = d;
                ovf_p[i]  = ovf0;
                sb_p[i]   = sb_in;
            end
            else
            begin
                rem_p[i]  = rem_reg[i-1];
                q_p[i]    = q_reg[i-1];
                xl_p[i]   = xl_reg[i-1];
                d_p[i]    = d_reg[i-1];
                ovf_p[i]  = ovf_reg[i-1];
                sb_p[i]   = sb_reg[i-1];
            end
            trial[i] = {rem_p[i], xl_p[i][Q_W-1-i]};
            if (trial[i] >= {1'b0, d_p[i]})
            begin
                rem_next[i] = D_W'(trial[i] - {1'b0, d_p[i]});
                q_next[i]   = q_p[i] | (Q_W'(1) << (Q_W - 1 - i));
            end
            else
            begin
                rem_next[i] = trial[i][D_W-1:0];
                q_next[i]   = q_p[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[Q_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_reg <= ovf_p;
            for (int i = 0; i < Q_W; i++)
            begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
                xl_reg[i]  <= xl_p[i];
                d_reg[i]   <= d_p[i];
                sb_reg[i]  <= sb_p[i];
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign q         = q_reg[Q_W-1];
    assign ovf       = ovf_reg[Q_W-1];
    assign sb_out    = sb_reg[Q_W-1];

endmodule
`default_nettype wire

// ----- hdl/heightmap_lambert_shading_core.sv -----
// Top level of the heightmap Lambert shading core.
`default_nettype none
// Shades one heightmap cell per beat. A cell's surface level (terrain plus water)
// is compared with its right and lower neighbors to form slopes, the slope
// vector is normalized, dotted with the configured light direction and mixed
// with the ambient level; the result scales a land, shallow-water ramp or deep
// water base color into 8-bit RGB. The datapath is one long pipeline: 7 front
// stages (slopes, normalizing shift, products), a 31-stage square root for the
// normal length, a 28-stage and a 17-stage divider for the cosine, and 4 stages
// for brightness and color, then the output register. One beat is accepted per
// clock while the pipeline is not stalled, and there are 88 register stages in
// all. A single stall enable holds the whole pipeline only when the output
// register is full, not taken, and the last stage holds a beat, so bubbles are
// squeezed out under backpressure. The light vector length runs through its own
// free-running square-root pipeline; config writes made while the core is idle
// are settled long before any new beat reaches the divider that uses them.
`include "heightmap_lambert_shading_core_assert.svh"
module heightmap_lambert_shading_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [hls_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [hls_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [hls_pkg::IN_W-1:0]       height_here,
    input  logic signed [hls_pkg::IN_W-1:0]       water_here,
    input  logic signed [hls_pkg::IN_W-1:0]       height_right,
    input  logic signed [hls_pkg::IN_W-1:0]       water_right,
    input  logic signed [hls_pkg::IN_W-1:0]       height_below,
    input  logic signed [hls_pkg::IN_W-1:0]       water_below,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hls_pkg::CH_W-1:0]              red,
    output logic [hls_pkg::CH_W-1:0]              green,
    output logic [hls_pkg::CH_W-1:0]              blue
);
    import hls_pkg::*;

    localparam int FRONT_N = 7;
    localparam int TAIL_N  = 4;

    // ---------------- configuration registers ----------------
    logic signed [LIGHT_W-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [AMB_W-1:0]          ambient_reg;
    logic [SCALE_W-1:0]        scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= LIGHT_X_RST;
            light_y_reg <= LIGHT_Y_RST;
            light_z_reg <= LIGHT_Z_RST;
            ambient_reg <= AMB_RST;
            scale_reg   <= SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIGHT_X: light_x_reg <= cfg_data;
                REG_LIGHT_Y: light_y_reg <= cfg_data;
                REG_LIGHT_Z: light_z_reg <= cfg_data;
                REG_AMBIENT: ambient_reg <= cfg_data;
                REG_SCALE:   scale_reg   <= cfg_data[SCALE_W-1:0];
                default:     ;
            endcase
        end
    end

    // ---------------- light length, free running ----------------
    logic [L2_W-1:0] l2_reg;
    logic [RL_W-1:0] rl;
    logic            light_zero;

    always_ff @(posedge clk)
    begin
        l2_reg <= L2_W'(L2_W'(light_x_reg) * L2_W'(light_x_reg))
                + L2_W'(L2_W'(light_y_reg) * L2_W'(light_y_reg))
                + L2_W'(L2_W'(light_z_reg) * L2_W'(light_z_reg));
    end

    assign light_zero = (light_x_reg == '0) && (light_y_reg == '0) && (light_z_reg == '0);

    hls_isqrt #(
        .RAD_W (RAD_L_W),
        .SB_W  (1)
    ) u_light_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (1'b1),
        .in_valid  (1'b1),
        .rad       ({l2_reg, {L_PAD{1'b0}}}),
        .sb_in     (1'b0),
        .out_valid (),
        .root      (rl),
        .sb_out    ()
    );

    // ---------------- pipeline control ----------------
    logic                en;
    logic [FRONT_N-1:0]  fv_reg;
    logic [TAIL_N-1:0]   tv_reg;
    logic                out_valid_reg;

    // advance unless the output is full and unread and the last stage holds a beat
    assign en       = !out_valid_reg || out_ready || !tv_reg[TAIL_N-1];
    assign in_ready = en;

    // ---------------- stage 1: level differences, water class ----------------
    logic signed [DIFF_W-1:0] dx_next, dy_next, dd_next;
    logic [WW_W-1:0]          ww_next;
    logic signed [INV_W-1:0]  inv_next;
    col_class_t               cls_next;

    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dd1_reg;
    logic signed [IN_W-1:0]   h1_reg;
    logic [WW_W-1:0]          ww1_reg;
    logic signed [INV_W-1:0]  inv1_reg;
    col_class_t               cls1_reg;

    always_comb
    begin
        dx_next = DIFF_W'(height_here) + DIFF_W'(water_here)
                - DIFF_W'(height_right) - DIFF_W'(water_right);
        dy_next = DIFF_W'(height_here) + DIFF_W'(water_here)
                - DIFF_W'(height_below) - DIFF_W'(water_below);
        dd_next = DIFF_W'(height_here) + DIFF_W'(ONE_Q20) - DIFF_W'(water_here);
        // only meaningful for shallow water, where the depth fits 11 bits
        ww_next  = WW_W'(water_here[10:0]) * WW_W'(WATER_MULT);
        inv_next = INV_W'(ONE_Q20) - $signed({1'b0, ww_next});
        if (water_here > WATER_EPS_RAW)
        begin
            cls_next = (water_here >= DEEP_RAW) ? COL_DEEP : COL_RAMP;
        end
        else
        begin
            cls_next = COL_LAND;    // dry or negative water
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;
            dd1_reg  <= dd_next;
            h1_reg   <= height_here;
            ww1_reg  <= ww_next;
            inv1_reg <= inv_next;
            cls1_reg <= cls_next;
        end
    end

    // ---------------- stage 2: slopes and ramp products ----------------
    logic signed [SLOPE_W-1:0] a2_reg, b2_reg;
    logic signed [P1_W-1:0]    p1_2_reg;
    logic signed [P2_W-1:0]    p2_2_reg;
    logic signed [IN_W-1:0]    h2_reg;
    logic signed [DIFF_W-1:0]  dd2_reg;
    logic signed [INV_W-1:0]   inv2_reg;
    col_class_t                cls2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg   <= SLOPE_W'(dx1_reg) * SLOPE_W'($signed({1'b0, scale_reg}));
            b2_reg   <= SLOPE_W'(dy1_reg) * SLOPE_W'($signed({1'b0, scale_reg}));
            p1_2_reg <= P1_W'(h1_reg) * P1_W'(inv1_reg);
            p2_2_reg <= P2_W'(dd1_reg) * P2_W'($signed({1'b0, ww1_reg}));
            h2_reg   <= h1_reg;
            dd2_reg  <= dd1_reg;
            inv2_reg <= inv1_reg;
            cls2_reg <= cls1_reg;
        end
    end

    // ---------------- stage 3: slope magnitudes, base color ----------------
    logic signed [BS_W-1:0] bsum;
    color_t                 col_next;
    logic [MAGA_W-1:0]      ma3_reg, mb3_reg;
    logic                   sa3_reg, sb3_reg;
    color_t                 col3_reg;

    always_comb
    begin
        bsum = BS_W'(p2_2_reg) + (BS_W'(p1_2_reg) <<< 1);
        case (cls2_reg)
            COL_RAMP:
            begin
                col_next.r = COMP_W'(p1_2_reg >>> 20);
                col_next.g = COMP_W'(inv2_reg);
                col_next.b = COMP_W'(bsum >>> 21);
            end
            COL_DEEP:
            begin
                col_next.r = '0;
                col_next.g = '0;
                col_next.b = COMP_W'(dd2_reg >>> 1);
            end
            default:
            begin
                col_next.r = COMP_W'(h2_reg);
                col_next.g = COMP_W'(ONE_Q20);
                col_next.b = COMP_W'(h2_reg);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma3_reg  <= MAGA_W'(a2_reg < 0 ? -a2_reg : a2_reg);
            mb3_reg  <= MAGA_W'(b2_reg < 0 ? -b2_reg : b2_reg);
            sa3_reg  <= a2_reg[SLOPE_W-1];
            sb3_reg  <= b2_reg[SLOPE_W-1];
            col3_reg <= col_next;
        end
    end

    // ---------------- stage 4: normalizing shift ----------------
    logic [MAGA_W-1:0] m_max;
    logic [K_W-1:0]    k_next;
    logic [MAGA_W-1:0] ma4_reg, mb4_reg;
    logic              sa4_reg, sb4_reg;
    logic [K_W-1:0]    k4_reg;
    color_t            col4_reg;

    // smallest k with (max >> k) below 2^26
    always_comb
    begin
        m_max  = (ma3_reg > mb3_reg) ? ma3_reg : mb3_reg;
        k_next = '0;
        for (int j = MAG_W; j < MAGA_W; j++)
        begin
            if (m_max[j])
            begin
                k_next = K_W'(j - MAG_W + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma4_reg  <= ma3_reg;
            mb4_reg  <= mb3_reg;
            sa4_reg  <= sa3_reg;
            sb4_reg  <= sb3_reg;
            k4_reg   <= k_next;
            col4_reg <= col3_reg;
        end
    end

    // ---------------- stage 5: shrunk slopes ----------------
    logic [MAG_W-1:0]         apm_next, bpm_next;
    logic [MAG_W-1:0]         apm5_reg, bpm5_reg;
    logic signed [SMAG_W-1:0] ap5_reg, bp5_reg;
    logic [ONEP_W-1:0]        onep5_reg;
    color_t                   col5_reg;

    assign apm_next = MAG_W'(ma4_reg >> k4_reg);
    assign bpm_next = MAG_W'(mb4_reg >> k4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            apm5_reg  <= apm_next;
            bpm5_reg  <= bpm_next;
            ap5_reg   <= sa4_reg ? -$signed({1'b0, apm_next}) : $signed({1'b0, apm_next});
            bp5_reg   <= sb4_reg ? -$signed({1'b0, bpm_next}) : $signed({1'b0, bpm_next});
            onep5_reg <= ONEP_W'(ONE_Q20) >> k4_reg;
            col5_reg  <= col4_reg;
        end
    end

    // ---------------- stage 6: squares and light products ----------------
    logic [SQ_W-1:0]         sqa6_reg, sqb6_reg, sqo6_reg;
    logic signed [PX_W-1:0]  px6_reg, py6_reg, pz6_reg;
    logic [ONEP_W-1:0]       onep6_reg;
    color_t                  col6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqa6_reg  <= SQ_W'(apm5_reg) * SQ_W'(apm5_reg);
            sqb6_reg  <= SQ_W'(bpm5_reg) * SQ_W'(bpm5_reg);
            sqo6_reg  <= SQ_W'(onep5_reg) * SQ_W'(onep5_reg);
            px6_reg   <= PX_W'(light_x_reg) * PX_W'(ap5_reg);
            py6_reg   <= PX_W'(light_y_reg) * PX_W'(bp5_reg);
            pz6_reg   <= PX_W'(light_z_reg) * PX_W'($signed({1'b0, onep5_reg}));
            onep6_reg <= onep5_reg;
            col6_reg  <= col5_reg;
        end
    end

    // ---------------- stage 7: normal length squared, dot product ----------------
    logic [S2_W-1:0]        s2_7_reg;
    logic signed [N_W-1:0]  n7_reg;
    logic [ONEP_W-1:0]      onep7_reg;
    color_t                 col7_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_7_reg  <= S2_W'(sqa6_reg) + S2_W'(sqb6_reg) + S2_W'(sqo6_reg);
            n7_reg    <= N_W'(px6_reg) + N_W'(py6_reg) - N_W'(pz6_reg);
            onep7_reg <= onep6_reg;
            col7_reg  <= col6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[FRONT_N-2:0], in_valid};
        end
    end

    // ---------------- normal length: rs = isqrt(s2 << 8) ----------------
    sqrt_sb_t         sq_sb_in, sq_sb_out;
    logic             sq_valid;
    logic [RS_W-1:0]  rs;

    assign sq_sb_in = '{n: n7_reg, onep: onep7_reg, col: col7_reg};

    hls_isqrt #(
        .RAD_W (RAD_S_W),
        .SB_W  ($bits(sqrt_sb_t))
    ) u_normal_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv_reg[FRONT_N-1]),
        .rad       ({s2_7_reg, {SQRT_PAD{1'b0}}}),
        .sb_in     (sq_sb_in),
        .out_valid (sq_valid),
        .root      (rs),
        .sb_out    (sq_sb_out)
    );

    // ---------------- t = (N << 16) / rs ----------------
    logic            npos;
    logic [X1_W-1:0] x1;
    div1_sb_t        d1_sb_in, d1_sb_out;
    logic            d1_valid, d1_ovf;
    logic [T_W-1:0]  t_q;

    assign npos     = sq_sb_out.n > 0;
    assign x1       = npos ? {sq_sb_out.n[N_W-2:0], {T_SHIFT{1'b0}}} : '0;
    assign d1_sb_in = '{rs: rs, onep: sq_sb_out.onep, npos: npos, col: sq_sb_out.col};

    hls_div #(
        .X_W  (X1_W),
        .D_W  (RS_W),
        .Q_W  (T_W),
        .SB_W ($bits(div1_sb_t))
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .x         (x1),
        .d         (rs),
        .sb_in     (d1_sb_in),
        .out_valid (d1_valid),
        .q         (t_q),
        .ovf       (d1_ovf),
        .sb_out    (d1_sb_out)
    );

    // ---------------- c = (t << 14) / rl, or (one' << 20) / rs with no light ----------------
    logic [X2_W-1:0] x2;
    logic [RS_W-1:0] dv2;
    div2_sb_t        d2_sb_in, d2_sb_out;
    logic            d2_valid, d2_ovf;
    logic [C_W-1:0]  c_q;

    always_comb
    begin
        if (light_zero)
        begin
            x2  = X2_W'({d1_sb_out.onep, {Z_SHIFT{1'b0}}});
            dv2 = d1_sb_out.rs;
        end
        else
        begin
            x2  = {t_q, {C_SHIFT{1'b0}}};
            dv2 = RS_W'(rl);
        end
    end

    // cosine forced to zero when the surface faces away from the light
    assign d2_sb_in = '{cz: !light_zero && !d1_sb_out.npos, col: d1_sb_out.col};

    hls_div #(
        .X_W  (X2_W),
        .D_W  (RS_W),
        .Q_W  (C_W),
        .SB_W ($bits(div2_sb_t))
    ) u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d1_valid),
        .x         (x2),
        .d         (dv2),
        .sb_in     (d2_sb_in),
        .out_valid (d2_valid),
        .q         (c_q),
        .ovf       (d2_ovf),
        .sb_out    (d2_sb_out)
    );

    // ---------------- tail: clamp, brightness, color scaling ----------------
    logic [C_W-1:0]          c_next;
    logic [C_W-1:0]          c_t1_reg;
    color_t                  col_t1_reg;
    logic [CM_W-1:0]         cm_t2_reg;
    color_t                  col_t2_reg;
    logic [BR_W-1:0]         br_t3_reg;
    color_t                  col_t3_reg;
    logic signed [PR_W-1:0]  pr_r_reg, pr_g_reg, pr_b_reg;
    logic [CH_W-1:0]         red_reg, green_reg, blue_reg;

    always_comb
    begin
        if (d2_sb_out.cz)
        begin
            c_next = '0;
        end
        else if (d2_ovf || (c_q > C_W'(C_MAX)))
        begin
            c_next = C_W'(C_MAX);
        end
        else
        begin
            c_next = c_q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_t1_reg   <= c_next;
            col_t1_reg <= d2_sb_out.col;
            cm_t2_reg  <= CM_W'(c_t1_reg) * CM_W'(C_W'(C_MAX) - C_W'(ambient_reg));
            col_t2_reg <= col_t1_reg;
            br_t3_reg  <= BR_W'(ambient_reg) + BR_W'(cm_t2_reg >> 16);
            col_t3_reg <= col_t2_reg;
            pr_r_reg   <= PR_W'(col_t3_reg.r) * PR_W'($signed({1'b0, br_t3_reg}));
            pr_g_reg   <= PR_W'(col_t3_reg.g) * PR_W'($signed({1'b0, br_t3_reg}));
            pr_b_reg   <= PR_W'(col_t3_reg.b) * PR_W'($signed({1'b0, br_t3_reg}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tv_reg <= '0;
        end
        else if (en)
        begin
            tv_reg <= {tv_reg[TAIL_N-2:0], d2_valid};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en && tv_reg[TAIL_N-1])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tv_reg[TAIL_N-1])
        begin
            red_reg   <= sat_channel(pr_r_reg);
            green_reg <= sat_channel(pr_g_reg);
            blue_reg  <= sat_channel(pr_b_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // ---------------- checks ----------------
    `HLS_ASSERT_HOLDS(a_stall_cause, !in_ready,
        out_valid_reg && !out_ready && tv_reg[TAIL_N-1], "input stalled without a full output")
    `HLS_ASSERT_HOLDS(a_t_range, d1_valid && d1_sb_out.npos, !d1_ovf,
        "t quotient exceeded its width")
    `HLS_ASSERT_HOLDS(a_bright_floor, tv_reg[2], br_t3_reg >= BR_W'(ambient_reg),
        "brightness below ambient level")
    `HLS_ASSERT_NEXT(a_out_load, en && tv_reg[TAIL_N-1], out_valid_reg,
        "finished beat not loaded into output register")

endmodule
`default_nettype wire

// ----- test/heightmap_lambert_shading_core_tb.sv -----
// Self-checking testbench for the heightmap Lambert shading core.
`timescale 1ns / 100ps
module heightmap_lambert_shading_core_tb;
    import hls_pkg::*;

    localparam int ONE         = 1 << 20;
    localparam int DRAIN_WAIT  = 120;   // pipeline is 88 deep, plus the light root
    localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
    localparam int RAND_ITEMS  = 300;   // per configuration phase

    typedef struct {
        logic signed [IN_W-1:0] hh, wh, hr, wr, hb, wb;
    } cell_t;

    typedef struct {
        logic [CH_W-1:0] r, g, b;
    } rgb_t;

    // Directed row: a cell, plus an expected color where it is obvious.
    typedef struct {
        cell_t tile;
        bit    typed;
        rgb_t  rgb;
    } row_t;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [IN_W-1:0] height_here, water_here, height_right;
    logic signed [IN_W-1:0] water_right, height_below, water_below;
    logic out_valid;
    logic out_ready;
    logic [CH_W-1:0] red, green, blue;

    // Shadow copy of the register file, updated as writes are issued.
    logic signed [LIGHT_W-1:0] lx_q, ly_q, lz_q;
    logic [AMB_W-1:0]          amb_q;
    logic [SCALE_W-1:0]        scale_q;

    rgb_t   pending_colors[$];
    bit     cur_typed;
    rgb_t   cur_rgb;
    bit     calm;          // no idling on either side while set
    int     mismatches;
    int     cells_sent;
    int     colors_checked;
    int     quiet_cycles;

    heightmap_lambert_shading_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .height_here (height_here),
        .water_here  (water_here),
        .height_right(height_right),
        .water_right (water_right),
        .height_below(height_below),
        .water_below (water_below),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red         (red),
        .green       (green),
        .blue        (blue)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
            begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // 8-bit channel: comp * brightness * 255 >> 36, clamped to 0..255.
    function automatic logic [CH_W-1:0] to_channel(longint comp, longint unsigned br);
        longint p;
        longint q;
        p = comp * longint'(br) * 255;
        if (p <= 0)
            return '0;
        q = p >>> 36;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Predicted color of one cell under the current shadow registers.
    function automatic rgb_t shade_cell(cell_t c);
        longint h, w, lvh, lvr, lvb, a, b, lx, ly, lz, ap, bp, onep, n;
        longint rc, gc, bc, ww, inv;
        longint unsigned ma, mb, m, s2, rs, l2, rl, t, cos_q, br;
        int   k;
        rgb_t res;
        h   = c.hh;
        w   = c.wh;
        lvh = h + w;
        lvr = longint'(c.hr) + longint'(c.wr);
        lvb = longint'(c.hb) + longint'(c.wb);
        a   = longint'(scale_q) * (lvh - lvr);
        b   = longint'(scale_q) * (lvh - lvb);
        lx  = lx_q;
        ly  = ly_q;
        lz  = lz_q;
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        m   = ONE;
        if (ma > m) m = ma;
        if (mb > m) m = mb;
        k = 0;
        while ((m >> k) >= (64'd1 << 26))
            k++;
        // shrink toward zero so the normal keeps its symmetry
        ap   = (a >= 0) ? (a >>> k) : -((-a) >>> k);
        bp   = (b >= 0) ? (b >>> k) : -((-b) >>> k);
        onep = ONE >> k;
        s2   = ap * ap + bp * bp + onep * onep;
        rs   = int_root(s2 << 8);
        if (rs == 0)
            rs = 1;
        l2 = lx * lx + ly * ly + lz * lz;
        if (l2 == 0)
        begin
            // no light direction: straight overhead
            cos_q = (longint'(onep) << 20) / rs;
        end
        else
        begin
            n = lx * ap + ly * bp - lz * onep;
            if (n <= 0)
            begin
                cos_q = 0;
            end
            else
            begin
                rl    = int_root(l2 << 20);
                t     = (longint'(n) << 16) / rs;
                cos_q = (t << 14) / rl;
            end
        end
        if (cos_q > 65536)
            cos_q = 65536;
        br = amb_q + ((cos_q * (65536 - amb_q)) >> 16);

        if (w > WATER_EPS_RAW)
        begin
            if (w >= DEEP_RAW)
            begin
                rc = 0;
                gc = 0;
                bc = (h + ONE - w) >>> 1;
            end
            else
            begin
                ww  = WATER_MULT * w;
                inv = ONE - ww;
                rc  = (h * inv) >>> 20;
                gc  = inv;
                bc  = ((h + ONE - w) * ww + 2 * h * inv) >>> 21;
            end
        end
        else
        begin
            // land, including negative water
            rc = h;
            gc = ONE;
            bc = h;
        end
        res.r = to_channel(rc, br);
        res.g = to_channel(gc, br);
        res.b = to_channel(bc, br);
        return res;
    endfunction

    // Input side: record what each accepted beat should produce.
    // Output side: compare against the oldest expectation.
    always @(posedge clk)
    begin
        rgb_t want;
        cell_t c;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready)
            begin
                c.hh = height_here;
                c.wh = water_here;
                c.hr = height_right;
                c.wr = water_right;
                c.hb = height_below;
                c.wb = water_below;
                pending_colors.push_back(cur_typed ? cur_rgb : shade_cell(c));
                cells_sent <= cells_sent + 1;
            end
            if (out_valid && out_ready)
            begin
                colors_checked <= colors_checked + 1;
                if (pending_colors.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected beat: rgb %0d %0d %0d", red, green, blue);
                end
                else
                begin
                    want = pending_colors.pop_front();
                    if (want.r !== red || want.g !== green || want.b !== blue)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("color mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                                     want.r, want.g, want.b, red, green, blue);
                    end
                end
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stall before each beat, none while calm.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // Register write, one per cycle; called at a falling edge.
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = d;
        case (idx)
            REG_LIGHT_X: lx_q = d;
            REG_LIGHT_Y: ly_q = d;
            REG_LIGHT_Z: lz_q = d;
            REG_AMBIENT: amb_q = d;
            REG_SCALE:   scale_q = d[SCALE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic set_light(int x, int y, int z, int amb, int scl);
        write_reg(REG_LIGHT_X, x[15:0]);
        write_reg(REG_LIGHT_Y, y[15:0]);
        write_reg(REG_LIGHT_Z, z[15:0]);
        write_reg(REG_AMBIENT, amb[15:0]);
        write_reg(REG_SCALE, scl[15:0]);
    endtask

    // Present one beat after a random gap; returns at the falling edge after
    // acceptance with valid still high, so back-to-back beats never drop it.
    task automatic send_cell(cell_t c, bit typed, rgb_t rgb);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        height_here  = c.hh;
        water_here   = c.wh;
        height_right = c.hr;
        water_right  = c.wr;
        height_below = c.hb;
        water_below  = c.wb;
        cur_typed    = typed;
        cur_rgb      = rgb;
        in_valid     = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Water values clustered on the land / ramp / deep thresholds.
    function automatic logic signed [IN_W-1:0] pick_water();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return $urandom_range(90, 120);
            2: return $urandom_range(1030, 1070);
            3: return $urandom_range(105, 1048);
            4: return -$urandom_range(0, 5000);
            default: return $urandom_range(1049, 400000);
        endcase
    endfunction

    // Mostly a neighborhood of similar heights, sometimes raw noise.
    function automatic cell_t random_cell();
        cell_t c;
        int base, span;
        if ($urandom_range(0, 4) == 0)
        begin
            c.hh = $urandom; c.wh = $urandom; c.hr = $urandom;
            c.wr = $urandom; c.hb = $urandom; c.wb = $urandom;
        end
        else
        begin
            base = $signed($urandom_range(0, 16'hFFFF) << 8) >>> 0;
            base = int'($signed(24'($urandom))) / (1 << $urandom_range(0, 8));
            span = 1 << $urandom_range(4, 18);
            c.hh = base;
            c.hr = base + $urandom_range(0, 2 * span) - span;
            c.hb = base + $urandom_range(0, 2 * span) - span;
            c.wh = pick_water();
            c.wr = pick_water();
            c.wb = pick_water();
        end
        return c;
    endfunction

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_colors.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    function automatic cell_t mk(int hh, int wh, int hr, int wr, int hb, int wb);
        cell_t c;
        c.hh = hh; c.wh = wh; c.hr = hr; c.wr = wr; c.hb = hb; c.wb = wb;
        return c;
    endfunction

    initial
    begin
        row_t rows[$];
        row_t rw;
        rgb_t none;
        int   ph;
        cfg_write = 1'b0;
        cfg_index = REG_LIGHT_X;
        cfg_data  = '0;
        in_valid  = 1'b0;
        height_here = '0; water_here = '0; height_right = '0;
        water_right = '0; height_below = '0; water_below = '0;
        cur_typed = 1'b0;
        cur_rgb   = '{default: '0};
        none      = '{default: '0};
        calm      = 1'b0;
        mismatches = 0;
        cells_sent = 0;
        colors_checked = 0;
        quiet_cycles = 0;
        lx_q = LIGHT_X_RST; ly_q = LIGHT_Y_RST; lz_q = LIGHT_Z_RST;
        amb_q = AMB_RST; scale_q = SCALE_RST;

        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed cells under the reset registers.
        // Deep water on the lowest terrain: blue goes negative, all black.
        rw = '{mk(-8388608, 1049, -8388608, 1049, -8388608, 1049), 1'b1, none};
        rows.push_back(rw);
        rw = '{mk(-8388608, 8388607, 0, 0, 0, 0), 1'b1, none};
        rows.push_back(rw);
        rw.typed = 1'b0; rw.rgb = none;
        rw.tile = mk(0, 0, 0, 0, 0, 0);                    rows.push_back(rw);
        rw.tile = mk(ONE, 0, ONE, 0, ONE, 0);              rows.push_back(rw);
        rw.tile = mk(8388607, 0, 8388607, 0, 8388607, 0);  rows.push_back(rw);
        rw.tile = mk(-8388608, 0, -8388608, 0, -8388608, 0); rows.push_back(rw);
        // water thresholds: land, just into the ramp, end of ramp, deep
        rw.tile = mk(ONE / 2, 104, ONE / 2, 104, ONE / 2, 104);   rows.push_back(rw);
        rw.tile = mk(ONE / 2, 105, ONE / 2, 105, ONE / 2, 105);   rows.push_back(rw);
        rw.tile = mk(ONE / 2, 1048, ONE / 2, 1048, ONE / 2, 1048); rows.push_back(rw);
        rw.tile = mk(ONE / 2, 1049, ONE / 2, 1049, ONE / 2, 1049); rows.push_back(rw);
        rw.tile = mk(ONE / 2, -5, ONE / 2, -5, ONE / 2, -5);       rows.push_back(rw);
        rw.tile = mk(ONE / 2, -8388608, ONE / 2, 0, ONE / 2, 0);   rows.push_back(rw);
        // steepest slopes both ways, both axes
        rw.tile = mk(8388607, 8388607, -8388608, -8388608, -8388608, -8388608);
        rows.push_back(rw);
        rw.tile = mk(-8388608, -8388608, 8388607, 8388607, 8388607, 8388607);
        rows.push_back(rw);
        rw.tile = mk(0, 0, 8388607, 0, -8388608, 0);  rows.push_back(rw);
        rw.tile = mk(0, 0, -8388608, 0, 8388607, 0);  rows.push_back(rw);
        rw.tile = mk(4000000, 500, 3990000, 0, 4010000, 700); rows.push_back(rw);
        rw.tile = mk(-1, -1, -1, -1, -1, -1);                  rows.push_back(rw);
        rw.tile = mk(8388607, 200, 8388000, 0, 8388607, 0);    rows.push_back(rw);

        foreach (rows[i])
            send_cell(rows[i].tile, rows[i].typed, rows[i].rgb);
        cur_typed = 1'b0;

        // Phases: reset registers, then extremes, zero light with a flat
        // surface, and random settings.
        for (ph = 0; ph < 5; ph++)
        begin
            wait_drained();
            case (ph)
                0: ;
                1: set_light(32767, 32767, 32767, 65535, 4096);
                2: set_light(-32768, -32768, -32768, 0, 1);
                3: set_light(0, 0, 0, 0, 0);
                default: set_light($urandom, $urandom, -$urandom_range(1, 32768),
                                   $urandom, $urandom_range(1, 4096));
            endcase
            for (int i = 0; i < RAND_ITEMS; i++)
            begin
                calm = ((i / 60) % 3) == 1;
                send_cell(random_cell(), 1'b0, none);
            end
            calm = 1'b0;
        end
        wait_drained();

        $display("shaded %0d cells over 5 register settings, %0d colors checked",
                 cells_sent, colors_checked);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- heightmap_lambert_shading_core.f -----
+incdir+hdl
hdl/hls_pkg.sv
hdl/hls_isqrt.sv
hdl/hls_div.sv
hdl/heightmap_lambert_shading_core.sv
test/heightmap_lambert_shading_core_tb.sv
